// File: hdl/wedf_pkg.sv
// shared constants and types for the window exact distinct finder
`default_nettype none
package wedf_pkg;

	localparam int WINDOW_MAX    = 64;
	localparam int WIN_AW        = $clog2(WINDOW_MAX);
	localparam int ALPHABET_SIZE = 26;
	localparam int LETTER_W      = 5;
	localparam int CNT_W         = 7;
	localparam int DIST_W        = 5;
	localparam int POS_W         = 17;
	localparam int LEN_W         = 7;
	localparam int TGT_W         = 5;
	localparam int START_W       = 16;
	localparam int CFG_IDX_W     = 1;

	localparam logic [POS_W-1:0]    MAX_LENGTH = POS_W'(65536);
	localparam logic [CNT_W-1:0]    CNT_MAX    = {CNT_W{1'b1}};
	localparam logic [LETTER_W-1:0] LAST_CODE  = LETTER_W'(ALPHABET_SIZE - 1);
	localparam logic [LEN_W-1:0]    LEN_MAX    = LEN_W'(WINDOW_MAX);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_DISTINCT = 1'd1;

	typedef struct packed {
		logic                clear;
		logic                inc;
		logic [LETTER_W-1:0] code;
		logic                evict;
		logic [LETTER_W-1:0] old;
	} cnt_ctrl_t;

	typedef struct packed {
		logic [DIST_W-1:0] distinct_d;
		logic [DIST_W-1:0] distinct_q;
	} cnt_stat_t;

endpackage
`default_nettype wire

// File: hdl/wedf_window_mem.sv
// circular letter store with registered read and write-through on address match
`default_nettype none
module wedf_window_mem (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            we,
	input  wire  [wedf_pkg::WIN_AW-1:0]    waddr,
	input  wire  [wedf_pkg::LETTER_W-1:0]  wdata,
	input  wire                            re,
	input  wire  [wedf_pkg::WIN_AW-1:0]    raddr,
	output logic [wedf_pkg::LETTER_W-1:0]  rdata
);
	import wedf_pkg::*;

	logic [LETTER_W-1:0] mem [WINDOW_MAX];
	logic [LETTER_W-1:0] rd_q;
	logic [LETTER_W-1:0] byp_data_q;
	logic                byp_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_q       <= mem[raddr];
			byp_data_q <= wdata;
		end
	end

	// read of the entry written in the same cycle returns the new letter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else if (re) begin
			byp_q <= we && (waddr == raddr);
		end
	end

	assign rdata = byp_q ? byp_data_q : rd_q;

endmodule
`default_nettype wire

// File: hdl/wedf_counts.sv
// per-letter occurrence counters and the distinct letter count
`default_nettype none
module wedf_counts (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wedf_pkg::cnt_ctrl_t   ctrl,
	output wedf_pkg::cnt_stat_t   stat
);
	import wedf_pkg::*;

	logic [CNT_W-1:0]  cnt_q [ALPHABET_SIZE];
	logic [CNT_W-1:0]  cnt_d [ALPHABET_SIZE];
	logic [DIST_W-1:0] distinct_q;
	logic [DIST_W-1:0] distinct_d;
	logic              any_zeroed;
	logic              any_fresh;

	// each lane sees its own decrement and increment, decrement first
	always_comb begin
		logic [CNT_W-1:0] c1;
		logic             dec;
		logic             inc;
		any_zeroed = 1'b0;
		any_fresh  = 1'b0;
		for (int i = 0; i < ALPHABET_SIZE; i++) begin
			dec = ctrl.evict && (ctrl.old == LETTER_W'(i)) && (cnt_q[i] != '0);
			inc = ctrl.inc && (ctrl.code == LETTER_W'(i));
			c1  = dec ? cnt_q[i] - CNT_W'(1) : cnt_q[i];
			if (dec && (c1 == '0)) begin
				any_zeroed = 1'b1;
			end
			if (inc && (c1 == '0)) begin
				any_fresh = 1'b1;
			end
			cnt_d[i] = (inc && (c1 != CNT_MAX)) ? c1 + CNT_W'(1) : c1;
		end
	end

	always_comb begin
		logic [DIST_W-1:0] d1;
		d1         = (any_zeroed && (distinct_q != '0)) ? distinct_q - DIST_W'(1) : distinct_q;
		distinct_d = any_fresh ? d1 + DIST_W'(1) : d1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ALPHABET_SIZE; i++) begin
				cnt_q[i] <= '0;
			end
			distinct_q <= '0;
		end else if (ctrl.clear) begin
			for (int i = 0; i < ALPHABET_SIZE; i++) begin
				cnt_q[i] <= '0;
			end
			distinct_q <= '0;
		end else if (ctrl.inc) begin
			for (int i = 0; i < ALPHABET_SIZE; i++) begin
				cnt_q[i] <= cnt_d[i];
			end
			distinct_q <= distinct_d;
		end
	end

	assign stat.distinct_d = distinct_d;
	assign stat.distinct_q = distinct_q;

endmodule
`default_nettype wire

// File: hdl/window_exact_distinct_finder.sv
// top level of the sliding window exact distinct letter finder
// Letters stream in one per request on s_tdata, with s_tlast on the final letter of a string.
// The block takes one letter every cycle while the output is not stalled: a letter waits in the input
// register, where the letter counters and the distinct count are updated, and its result, if any, is
// loaded into the output register as the letter leaves. A string gives exactly one result: found with
// the start index of the first window of window_length letters (clamped to 1..64) holding exactly
// target_distinct distinct letters, or not found at the last letter. Letters after a match are ignored
// and all state clears after the last letter. The letter store is a 64-entry memory read one letter
// ahead of use, so the evicted letter is ready when its item reaches the input register. No clearing
// pass is needed after reset. Write configuration only while the block is idle.
`default_nettype none
module window_exact_distinct_finder (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire  [0:0]  cfg_index,
	input  wire  [6:0]  cfg_wdata,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,   // [4:0] letter, [7:5] zero
	input  wire         s_tlast,   // last_letter
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [23:0] m_tdata    // [0] found, [16:1] start_index, [23:17] zero
);
	import wedf_pkg::*;

	logic [LEN_W-1:0]    window_length_q;
	logic [TGT_W-1:0]    target_distinct_q;
	logic [LEN_W-1:0]    len_eff;

	logic                s1_valid;
	logic [LETTER_W-1:0] letter_s1;
	logic                last_s1;

	logic [POS_W-1:0]    pos_q;
	logic [POS_W-1:0]    pos_d;
	logic [POS_W-1:0]    pos_inc;
	logic                match_q;

	logic                out_valid_q;
	logic                found_q;
	logic [START_W-1:0]  start_q;

	logic                accept;
	logic                adv;
	logic                proc;
	logic                active;
	logic                evict;
	logic                match_now;
	logic                emit;
	logic [LETTER_W-1:0] code;
	logic [LETTER_W-1:0] old_raw;
	logic [LETTER_W-1:0] old_code;
	logic [WIN_AW-1:0]   raddr;
	logic [START_W-1:0]  start_d;
	cnt_ctrl_t           cnt_ctrl;
	cnt_stat_t           cnt_stat;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q   <= LEN_W'(1);
			target_distinct_q <= TGT_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WINDOW_LENGTH:   window_length_q   <= cfg_wdata[LEN_W-1:0];
				REG_TARGET_DISTINCT: target_distinct_q <= cfg_wdata[TGT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		priority if (window_length_q == '0) begin
			len_eff = LEN_W'(1);
		end else if (window_length_q > LEN_MAX) begin
			len_eff = LEN_MAX;
		end else begin
			len_eff = window_length_q;
		end
	end

	// handshake
	assign adv      = !out_valid_q || m_tready;
	assign s_tready = !s1_valid || adv;
	assign accept   = s_tvalid && s_tready;
	assign proc     = s1_valid && adv;
	assign active   = proc && !match_q && (pos_q < MAX_LENGTH);

	assign code     = (letter_s1 > LAST_CODE) ? LAST_CODE : letter_s1;
	assign old_code = (old_raw > LAST_CODE) ? LAST_CODE : old_raw;
	assign evict    = active && (pos_q >= POS_W'(len_eff));
	assign pos_inc  = pos_q + POS_W'(1);

	always_comb begin
		priority if (proc && last_s1) begin
			pos_d = '0;
		end else if (active) begin
			pos_d = pos_inc;
		end else begin
			pos_d = pos_q;
		end
	end

	// eviction address of the item being accepted, one letter ahead
	assign raddr = pos_d[WIN_AW-1:0] - len_eff[WIN_AW-1:0];

	wedf_window_mem u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (active),
		.waddr  (pos_q[WIN_AW-1:0]),
		.wdata  (code),
		.re     (accept),
		.raddr  (raddr),
		.rdata  (old_raw)
	);

	assign cnt_ctrl.clear = proc && last_s1;
	assign cnt_ctrl.inc   = active;
	assign cnt_ctrl.code  = code;
	assign cnt_ctrl.evict = evict;
	assign cnt_ctrl.old   = old_code;

	wedf_counts u_counts (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (cnt_ctrl),
		.stat   (cnt_stat)
	);

	assign match_now = active && (pos_inc >= POS_W'(len_eff))
		&& (cnt_stat.distinct_d == target_distinct_q);
	assign emit      = match_now || (last_s1 && !match_q);
	assign start_d   = START_W'(pos_inc - POS_W'(len_eff));

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (accept) begin
			s1_valid <= 1'b1;
		end else if (adv) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			letter_s1 <= s_tdata[LETTER_W-1:0];
			last_s1   <= s_tlast;
		end
	end

	// string state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			match_q <= 1'b0;
		end else begin
			pos_q <= pos_d;
			if (proc && last_s1) begin
				match_q <= 1'b0;
			end else if (match_now) begin
				match_q <= 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= proc && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && emit) begin
			found_q <= match_now;
			start_q <= match_now ? start_d : '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'b0, start_q, found_q};

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && last_s1) |=> (pos_q == '0) && !match_q)
		else $error("string state not cleared after last letter");

	a_one_match: assert property (@(posedge clk) disable iff (!arst_n)
		match_now |-> !match_q)
		else $error("second match in one string");

	a_distinct_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_stat.distinct_q <= DIST_W'(ALPHABET_SIZE))
		else $error("distinct count above alphabet size");

	a_stall_holds_item: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> s1_valid && out_valid_q && !m_tready)
		else $error("input stalled with room to advance");

endmodule
`default_nettype wire
